### design/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int WORD_BITS          = 32;
    localparam int FRACTION_BITS_DEF  = 8;
    localparam int WIDE_BITS          = 2 * WORD_BITS + 1;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_INT = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]                  operation;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } item_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        a_greater;
        logic                        a_less;
        logic                        a_equal;
        logic                        divide_by_zero;
    } result_t;

    // Per-transaction data carried along the cell chain
    typedef struct packed {
        logic [3:0]             op;
        logic [WORD_BITS-1:0]   res;
        logic [2*WORD_BITS-1:0] prod;
        logic                   neg;
        logic                   gt;
        logic                   lt;
        logic                   eq;
        logic                   dz;
        logic [WORD_BITS-1:0]   rem;
        logic [WORD_BITS-1:0]   dvs;
    } side_t;

    // Apply sign to a magnitude, saturating to the signed word range
    function automatic logic [WORD_BITS-1:0] sat_signed(input logic [WIDE_BITS-1:0] mag,
                                                       input logic neg);
        logic [WIDE_BITS-1:0] pos_max;
        logic [WORD_BITS-1:0] r;
        pos_max = WIDE_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
        if (neg) begin
            if (mag > pos_max + WIDE_BITS'(1))
                r = {1'b1, {(WORD_BITS-1){1'b0}}};
            else
                r = WORD_BITS'(0) - mag[WORD_BITS-1:0];
        end
        else begin
            if (mag > pos_max)
                r = {1'b0, {(WORD_BITS-1){1'b1}}};
            else
                r = mag[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_front import fpa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NQ            = WORD_BITS + FRACTION_BITS
) (
    input  item_t            item,
    output side_t            side,
    output logic [NQ-1:0]    nq
);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic                 lt;
    logic                 gt;

    assign a  = item.operand_a;
    assign b  = item.operand_b;
    assign ma = a[WORD_BITS-1] ? (WORD_BITS'(0) - a) : a;
    assign mb = b[WORD_BITS-1] ? (WORD_BITS'(0) - b) : b;
    assign lt = item.operand_a < item.operand_b;
    assign gt = item.operand_b < item.operand_a;

    // Dividend is the operand magnitude with the fraction bits appended
    assign nq = {ma, {FRACTION_BITS{1'b0}}};

    always_comb
    begin
        side      = '0;
        side.op   = item.operation;
        side.prod = {{WORD_BITS{1'b0}}, ma} * {{WORD_BITS{1'b0}}, mb};
        side.neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        side.gt   = gt;
        side.lt   = lt;
        side.eq   = (a == b);
        side.dz   = (item.operation == OP_DIV) && (b == '0);
        side.rem  = '0;
        side.dvs  = mb;
        unique case (item.operation)
            OP_ADD:  side.res = a + b;
            OP_SUB:  side.res = a - b;
            OP_MIN:  side.res = lt ? a : b;
            OP_MAX:  side.res = gt ? a : b;
            OP_INC:  side.res = a + WORD_BITS'(1);
            OP_DEC:  side.res = a - WORD_BITS'(1);
            OP_INT:  side.res = WORD_BITS'(item.operand_a >>> FRACTION_BITS);
            default: side.res = '0;
        endcase
    end
endmodule
`default_nettype wire

### design/fpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_cell import fpa_pkg::*; #(
    parameter int NQ = WORD_BITS + FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  side_t         up_side,
    input  logic [NQ-1:0] up_nq,
    output logic          dn_valid,
    input  logic          dn_ready,
    output side_t         dn_side,
    output logic [NQ-1:0] dn_nq
);
    logic                 valid_reg;
    side_t                side_reg;
    side_t                side_next;
    logic [NQ-1:0]        nq_reg;
    logic [NQ-1:0]        nq_next;
    logic [WORD_BITS:0]   r2;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    // One restoring division step: shift in a dividend bit, trial subtract
    assign r2   = {up_side.rem, up_nq[NQ-1]};
    assign diff = r2 - {1'b0, up_side.dvs};
    assign ge   = r2 >= {1'b0, up_side.dvs};

    always_comb
    begin
        side_next     = up_side;
        side_next.rem = ge ? diff[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
        nq_next       = {up_nq[NQ-2:0], ge};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            side_reg <= side_next;
            nq_reg   <= nq_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_nq    = nq_reg;
endmodule
`default_nettype wire

### design/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_back import fpa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NQ            = WORD_BITS + FRACTION_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  side_t         up_side,
    input  logic [NQ-1:0] up_nq,
    output logic          result_valid,
    input  logic          result_stall,
    output result_t       result
);
    localparam logic [WIDE_BITS-1:0] HALF = WIDE_BITS'(1) << (FRACTION_BITS - 1);

    logic                 valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic                 round_up;
    logic [NQ:0]          q_div;
    logic [WIDE_BITS-1:0] s_mul;
    logic [WIDE_BITS-1:0] q_mul;

    // Round half away from zero on the magnitudes
    assign round_up = up_side.rem >= (up_side.dvs - up_side.rem);
    assign q_div    = {1'b0, up_nq} + {{NQ{1'b0}}, round_up};
    assign s_mul    = {1'b0, up_side.prod} + HALF;
    assign q_mul    = s_mul >> FRACTION_BITS;

    always_comb
    begin
        result_next.a_greater      = up_side.gt;
        result_next.a_less         = up_side.lt;
        result_next.a_equal        = up_side.eq;
        result_next.divide_by_zero = up_side.dz;
        if (up_side.op == OP_MUL)
            result_next.result_value = sat_signed(q_mul, up_side.neg);
        else if (up_side.op == OP_DIV)
            result_next.result_value = up_side.dz ? '0 :
                sat_signed(WIDE_BITS'(q_div), up_side.neg);
        else
            result_next.result_value = up_side.res;
    end

    assign up_ready = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;
endmodule
`default_nettype wire

### design/fixed_point_alu.sv
// Signed fixed-point ALU on 32-bit raw words with FRACTION_BITS fraction bits (Q24.8 by
// default). A transaction on item carries an operation and two operands; each yields one
// transaction on result with the value and the greater/less/equal flags. The block takes
// one transaction per cycle unless result_stall backs up the chain, and returns results
// in order: each transaction, whatever its operation, walks through the row of division
// cells, one quotient bit per cell, and then through the output register.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu import fpa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);
    // One cell per quotient bit of the widened dividend
    localparam int NQ = WORD_BITS + FRACTION_BITS;

    side_t         side_w  [0:NQ];
    logic [NQ-1:0] nq_w    [0:NQ];
    logic          valid_w [0:NQ];
    logic          ready_w [0:NQ];

    // Operand prep: flags, simple results, magnitudes and the raw product
    fpa_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .NQ            (NQ)
    ) u_front (
        .item (item),
        .side (side_w[0]),
        .nq   (nq_w[0])
    );

    assign valid_w[0] = item_valid;
    // Hold the input whenever the first cell cannot take a transaction
    assign item_stall = !ready_w[0];

    // Chain of division cells; each advances when its successor frees up
    for (genvar i = 0; i < NQ; i++)
    begin : g_cell
        fpa_cell #(
            .NQ (NQ)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_w[i]),
            .up_ready (ready_w[i]),
            .up_side  (side_w[i]),
            .up_nq    (nq_w[i]),
            .dn_valid (valid_w[i+1]),
            .dn_ready (ready_w[i+1]),
            .dn_side  (side_w[i+1]),
            .dn_nq    (nq_w[i+1])
        );
    end

    // Round, saturate, select and drive the output register
    fpa_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .NQ            (NQ)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (valid_w[NQ]),
        .up_ready     (ready_w[NQ]),
        .up_side      (side_w[NQ]),
        .up_nq        (nq_w[NQ]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );
endmodule
`default_nettype wire

### design/fpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker import fpa_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input transaction changed under stall");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed under stall");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot({result.a_greater, result.a_less, result.a_equal}))
        else $error("comparison flags not one-hot");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_by_zero |-> result.result_value == '0)
        else $error("divide by zero with nonzero value");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

### bench/fixed_point_alu_tb.sv
`timescale 1ns / 1ps
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEF;
    localparam int LATENCY = WORD_BITS + FRAC + 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1700;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    fixed_point_alu dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    item_t   pending_items[$];
    result_t expected_results[$];
    int      failures;
    int      idle_cycles;
    int      send_gap;
    int      recv_gap;
    bit      hold_sender;
    bit      sent_item;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Saturate a signed magnitude to the word range.
    function automatic logic [31:0] clamp_word(logic [127:0] mag, bit neg);
        if (neg)
            return (mag > 128'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Exact fixed-point ALU result, rounding half away from zero.
    function automatic result_t alu_outcome(item_t it);
        result_t r;
        logic signed [31:0] a, b;
        logic [127:0] ma, mb, prod, num, quot, rem;
        bit neg;
        a = it.operand_a;
        b = it.operand_b;
        ma = a[31] ? 128'(-{32'hFFFF_FFFF, a}) & 128'hFFFF_FFFF : 128'(a);
        mb = b[31] ? 128'(-{32'hFFFF_FFFF, b}) & 128'hFFFF_FFFF : 128'(b);
        neg = a[31] ^ b[31];
        r = '0;
        r.a_greater = a > b;
        r.a_less = a < b;
        r.a_equal = a == b;
        case (it.operation)
            OP_ADD: r.result_value = a + b;
            OP_SUB: r.result_value = a - b;
            OP_MUL:
            begin
                prod = ma * mb + (128'd1 << (FRAC - 1));
                r.result_value = clamp_word(prod >> FRAC, neg);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    num = ma << FRAC;
                    quot = num / mb;
                    rem = num % mb;
                    if (rem >= mb - rem)
                        quot = quot + 1;
                    r.result_value = clamp_word(quot, neg);
                end
            end
            OP_MIN: r.result_value = (a < b) ? a : b;
            OP_MAX: r.result_value = (a > b) ? a : b;
            OP_INC: r.result_value = a + 1;
            OP_DEC: r.result_value = a - 1;
            OP_INT: r.result_value = a >>> FRAC;
            default: r.result_value = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return 32'($signed($urandom_range(0, 2048)) - 1024);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        item_t it;
        it.operation = op;
        it.operand_a = a;
        it.operand_b = b;
        pending_items.push_back(it);
    endtask

    // Driver: present transactions on the falling edge, hold while stalled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sent_item)
            begin
                send_gap <= $urandom_range(0, 10);
                if (send_gap == 0 && pending_items.size() > 1 && !hold_sender)
                begin
                    // back-to-back: keep valid high, advance the payload
                    void'(pending_items.pop_front());
                    item <= pending_items[0];
                end
                else
                begin
                    void'(pending_items.pop_front());
                    item_valid <= 1'b0;
                end
            end
            else if (!item_valid && !hold_sender && pending_items.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else
                begin
                    item <= pending_items[0];
                    item_valid <= 1'b1;
                end
            end
            // stall drawn per result
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Monitor: sample handshakes on the rising edge and check results.
    always @(posedge clk)
    begin
        result_t want;
        sent_item <= rst_n && item_valid && !item_stall;
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (item_valid && !item_stall)
                expected_results.push_back(alu_outcome(item));
            if (result_valid && !result_stall)
            begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: mismatch expected val=%h gt=%b lt=%b eq=%b dz=%b",
                            $time, want.result_value, want.a_greater, want.a_less,
                            want.a_equal, want.divide_by_zero);
                        $display("%0t:          actual   val=%h gt=%b lt=%b eq=%b dz=%b",
                            $time, result.result_value, result.a_greater, result.a_less,
                            result.a_equal, result.divide_by_zero);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] op;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        failures = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_sender = 1'b0;
        sent_item = 1'b0;

        // Directed: every operation, field extremes, divide by zero, overflow.
        queue_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        queue_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_item(OP_MUL, 32'h0000_0080, 32'h0000_0001);
        queue_item(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        queue_item(OP_DIV, 32'h0000_1234, 32'h0000_0000);
        queue_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_item(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_item(OP_DIV, 32'h0000_0100, 32'h0000_0300);
        queue_item(OP_DIV, 32'hFFFF_FF00, 32'h0000_0200);
        queue_item(OP_MIN, 32'h0000_0005, 32'h0000_0005);
        queue_item(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(OP_INC, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_item(OP_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_item(OP_INT, 32'hFFFF_FF01, 32'h0000_0000);
        queue_item(OP_INT, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_item(4'd9, 32'h0000_0001, 32'h0000_0002);
        queue_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random: mostly valid operations, a few unknown codes.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            queue_item(op, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'd0
                                                                        : pick_operand());
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pause the sender once until the pipeline has drained.
        wait (pending_items.size() < RANDOM_ITEMS / 2);
        @(negedge clk);
        hold_sender = 1'b1;
        wait (!item_valid && expected_results.size() == 0);
        @(negedge clk);
        hold_sender = 1'b0;

        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### files.f
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_cell.sv
design/fpa_back.sv
design/fixed_point_alu.sv
design/fpa_checker.sv
bench/fixed_point_alu_tb.sv
